// ----- design/pat_pkg.sv -----
// Shared types and codes for the priority aging task picker.
// Used by pat_ctrl, pat_dp and priority_aging_task_picker; no dependencies.

package pat_pkg;

    // action codes
    localparam logic [2:0] ACT_INSTALL = 3'd0;
    localparam logic [2:0] ACT_REMOVE  = 3'd1;
    localparam logic [2:0] ACT_KILL    = 3'd2;
    localparam logic [2:0] ACT_SET_RS  = 3'd3;
    localparam logic [2:0] ACT_CHECK   = 3'd4;
    localparam logic [2:0] ACT_YIELD   = 3'd5;

    // slot status codes
    typedef logic [1:0] slot_status_t;
    localparam slot_status_t ST_IDLE    = 2'd0;
    localparam slot_status_t ST_RUNNING = 2'd1;
    localparam slot_status_t ST_ZOMBIE  = 2'd2;

    // width of the zombie mask in a result item
    localparam int ZMASK_W = 16;

    typedef struct packed {
        logic [2:0] action;
        logic [3:0] slot;
        logic [7:0] priority_req;
    } task_item_t;

    typedef struct packed {
        logic [3:0]         current_slot;
        logic               current_valid;
        logic               switched;
        logic [ZMASK_W-1:0] new_zombies;
    } result_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture incoming item
        logic exec;      // decode and apply item, start a run if needed
        logic scan;      // one slot of the schedule scan
        logic finish;    // apply the pick
        logic deliver;   // hand result to the output register
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic run_go;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- design/priority_aging_task_picker.sv -----
// Top level of the priority aging task picker: controller plus datapath.
// Depends on pat_pkg, pat_ctrl and pat_dp.
//
//  channel   signals                             dir   moves
//  task      task_valid, task_stall, task_item   in    one action item
//  result    result_valid, result_stall,         out   one result per item
//            result_item
//
// An item is taken only while the sequencer is idle. Install, remove, kill,
// set-resched, a check that does not run and unused codes go from decode
// straight to delivery. A schedule run scans one slot per cycle through the
// priority/age memory read port, then applies the pick and delivers; the
// sequencer takes the next item only once its result is registered.
// A held result does not block the next accept; the item after it waits.
// Reset clears the slot table at once; no clearing pass.

module priority_aging_task_picker #(
    parameter int NUM_SLOTS = 16,
    parameter int AGE_BITS  = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   task_valid,
    output logic                   task_stall,
    input  pat_pkg::task_item_t    task_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output pat_pkg::result_item_t  result_item
);

    pat_pkg::ctl_cmd_t   cmd;
    pat_pkg::dp_status_t status;

    pat_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_stall (task_stall),
        .status     (status),
        .cmd        (cmd)
    );

    pat_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .AGE_BITS  (AGE_BITS),
        .PRIO_BITS (PRIO_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .task_item    (task_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

// ----- design/pat_ctrl.sv -----
// Sequencer for the task picker: steps each item through decode and delivery,
// with scan and finish between them when a run starts. Depends on pat_pkg.

module pat_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   task_valid,
    output logic                   task_stall,
    input  pat_pkg::dp_status_t    status,
    output pat_pkg::ctl_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        task_stall  = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                task_stall = 1'b0;
                if (task_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.run_go ? S_SCAN : S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                cmd.deliver = 1'b1;
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/pat_dp.sv -----
// Datapath for the task picker: slot table, priority/age memories, scan
// compare, and result register. Depends on pat_pkg.

module pat_dp #(
    parameter int NUM_SLOTS = 16,
    parameter int AGE_BITS  = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pat_pkg::ctl_cmd_t      cmd,
    output pat_pkg::dp_status_t    status,
    input  pat_pkg::task_item_t    task_item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output pat_pkg::result_item_t  result_item
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    pat_pkg::task_item_t item_reg;

    logic [NUM_SLOTS-1:0]                        present_reg;
    logic [NUM_SLOTS-1:0]                        kill_reg;
    logic [NUM_SLOTS-1:0]                        resched_reg;
    pat_pkg::slot_status_t [NUM_SLOTS-1:0]       status_reg;

    // priority and age; an entry is only meaningful while its slot is present
    logic [PRIO_BITS-1:0] prio_mem [NUM_SLOTS];
    logic [AGE_BITS-1:0]  age_mem  [NUM_SLOTS];
    logic [PRIO_BITS-1:0] prio_rd_reg;
    logic [AGE_BITS-1:0]  age_rd_reg;

    logic [IDX_W-1:0]     scan_reg;
    logic [PRIO_BITS-1:0] best_prio_reg;
    logic [AGE_BITS-1:0]  best_age_reg;
    logic                 picked_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [IDX_W-1:0]     run_reg;
    logic                 known_reg;
    logic                 sw_reg;
    logic [pat_pkg::ZMASK_W-1:0] zmask_reg;

    logic                  result_valid_reg;
    pat_pkg::result_item_t result_reg;

    logic [IDX_W-1:0]     slot_idx;
    logic                 slot_ok;
    logic [NUM_SLOTS-1:0] avail;
    logic [NUM_SLOTS-1:0] newz;
    logic [pat_pkg::ZMASK_W-1:0] zm;
    logic                 run_go;
    logic                 scan_last;
    logic                 out_free;
    logic [AGE_BITS-1:0]  age_eff;
    logic [AGE_BITS-1:0]  age_wb;
    logic                 take;
    logic                 stay;
    logic                 prio_we;
    logic                 age_we;
    logic [IDX_W-1:0]     age_wa;
    logic [AGE_BITS-1:0]  age_wd;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;

    assign slot_idx = IDX_W'(item_reg.slot);
    assign slot_ok  = 32'(item_reg.slot) < NUM_SLOTS;

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            avail[i] = present_reg[i] &&
                       (status_reg[i] == pat_pkg::ST_IDLE ||
                        status_reg[i] == pat_pkg::ST_RUNNING);
        end
    end

    assign newz = avail & kill_reg;

    for (genvar g = 0; g < pat_pkg::ZMASK_W; g++)
    begin : g_zm
        if (g < NUM_SLOTS)
        begin : g_in
            assign zm[g] = newz[g];
        end
        else
        begin : g_out
            assign zm[g] = 1'b0;
        end
    end

    assign run_go = (item_reg.action == pat_pkg::ACT_YIELD) ||
                    (item_reg.action == pat_pkg::ACT_CHECK && known_reg &&
                     (resched_reg[run_reg] ||
                      status_reg[run_reg] == pat_pkg::ST_ZOMBIE));

    assign scan_last = (scan_reg == IDX_W'(NUM_SLOTS - 1));
    assign out_free  = !result_valid_reg || !result_stall;

    assign status.run_go    = run_go;
    assign status.scan_last = scan_last;
    assign status.out_free  = out_free;

    // the current task's age counts as zero for the whole run
    assign age_eff = (known_reg && run_reg == scan_reg) ? '0 : age_rd_reg;
    assign age_wb  = (avail[scan_reg] && age_eff != '1) ? age_eff + 1'b1 : age_eff;
    assign take    = avail[scan_reg] && prio_rd_reg >= best_prio_reg &&
                     age_eff >= best_age_reg;
    assign stay    = !picked_reg || (known_reg && pick_reg == run_reg);

    assign prio_we = cmd.exec && item_reg.action == pat_pkg::ACT_INSTALL && slot_ok;

    always_comb
    begin
        age_we = 1'b0;
        age_wa = slot_idx;
        age_wd = '0;
        priority if (prio_we)
        begin
            age_we = 1'b1;
        end
        else if (cmd.scan)
        begin
            age_we = 1'b1;
            age_wa = scan_reg;
            age_wd = age_wb;
        end
        else if (cmd.finish)
        begin
            age_we = stay ? known_reg : 1'b1;
            age_wa = stay ? run_reg : pick_reg;
        end
    end

    assign rd_en   = cmd.exec || (cmd.scan && !scan_last);
    assign rd_addr = cmd.exec ? '0 : IDX_W'(scan_reg + 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= task_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            prio_mem[slot_idx] <= PRIO_BITS'(item_reg.priority_req);
        end
        if (age_we)
        begin
            age_mem[age_wa] <= age_wd;
        end
        if (rd_en)
        begin
            prio_rd_reg <= prio_mem[rd_addr];
            age_rd_reg  <= age_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg   <= '0;
            kill_reg      <= '0;
            resched_reg   <= '0;
            status_reg    <= '0;
            scan_reg      <= '0;
            best_prio_reg <= '0;
            best_age_reg  <= '0;
            picked_reg    <= 1'b0;
            pick_reg      <= '0;
            run_reg       <= '0;
            known_reg     <= 1'b0;
            sw_reg        <= 1'b0;
            zmask_reg     <= '0;
        end
        else if (cmd.exec)
        begin
            sw_reg    <= 1'b0;
            zmask_reg <= run_go ? zm : '0;
            unique case (item_reg.action)
                pat_pkg::ACT_INSTALL, pat_pkg::ACT_REMOVE:
                begin
                    if (slot_ok)
                    begin
                        present_reg[slot_idx] <= (item_reg.action == pat_pkg::ACT_INSTALL);
                        status_reg[slot_idx]  <= pat_pkg::ST_IDLE;
                        kill_reg[slot_idx]    <= 1'b0;
                        resched_reg[slot_idx] <= 1'b0;
                        if (item_reg.action == pat_pkg::ACT_REMOVE && known_reg &&
                            run_reg == slot_idx)
                        begin
                            known_reg <= 1'b0;
                            run_reg   <= '0;
                        end
                    end
                end
                pat_pkg::ACT_KILL:
                begin
                    if (slot_ok && present_reg[slot_idx])
                    begin
                        kill_reg[slot_idx] <= 1'b1;
                    end
                end
                pat_pkg::ACT_SET_RS:
                begin
                    if (known_reg)
                    begin
                        resched_reg[run_reg] <= 1'b1;
                    end
                end
                pat_pkg::ACT_CHECK, pat_pkg::ACT_YIELD:
                begin
                    if (run_go)
                    begin
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            if (newz[i])
                            begin
                                status_reg[i] <= pat_pkg::ST_ZOMBIE;
                            end
                        end
                        scan_reg      <= '0;
                        best_prio_reg <= '0;
                        best_age_reg  <= '0;
                        picked_reg    <= 1'b0;
                        pick_reg      <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.scan)
        begin
            if (take)
            begin
                best_prio_reg <= prio_rd_reg;
                best_age_reg  <= age_eff;
                pick_reg      <= scan_reg;
                picked_reg    <= 1'b1;
            end
            if (!scan_last)
            begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
        else if (cmd.finish)
        begin
            if (known_reg)
            begin
                resched_reg[run_reg] <= 1'b0;
            end
            if (!stay)
            begin
                if (known_reg && status_reg[run_reg] == pat_pkg::ST_RUNNING)
                begin
                    status_reg[run_reg] <= pat_pkg::ST_IDLE;
                end
                status_reg[pick_reg] <= pat_pkg::ST_RUNNING;
                run_reg   <= pick_reg;
                known_reg <= 1'b1;
                sw_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.deliver && out_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.deliver && out_free)
        begin
            result_reg.current_slot  <= known_reg ? 4'(run_reg) : 4'd0;
            result_reg.current_valid <= known_reg;
            result_reg.switched      <= sw_reg;
            result_reg.new_zombies   <= zmask_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule
